[rtl/tst_pkg.sv]
// tab stop table package: command codes, payload structs, scan unit types
// no dependencies; imported by tab_stop_table and tst_find
`timescale 1ns / 1ps

package tst_pkg;

	// command codes
	localparam logic [2:0] CMD_SET       = 3'd0;
	localparam logic [2:0] CMD_CLEAR     = 3'd1;
	localparam logic [2:0] CMD_DEFAULT   = 3'd2;
	localparam logic [2:0] CMD_CLEAR_ALL = 3'd3;
	localparam logic [2:0] CMD_FORWARD   = 3'd4;
	localparam logic [2:0] CMD_BACK      = 3'd5;

	// bitmap is stored as 32-bit words
	localparam int WORD_W = 32;
	localparam int IDX_W  = 5;
	// word index of an 8-bit column
	localparam int CWI_W  = 3;
	// stop at every eighth column inside one word
	localparam logic [WORD_W-1:0] DEFAULT_WORD = 32'h0101_0101;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] column;
		logic [7:0] line_max_col;
	} in_item_t;

	typedef struct packed {
		logic [7:0] new_column;
		logic       moved;
	} out_item_t;

	// request to the shared word scan unit
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		logic              backward;
	} find_req_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} find_rsp_t;

endpackage

[rtl/tab_stop_table.sv]
// tab stop table top level: command sequencer, word valid bits, bitmap ram
// depends on tst_pkg, tst_ram, tst_find
`timescale 1ns / 1ps
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one command per transaction.
//     set, clear, reset-to-default and clear-all give no result; forward and
//     back tab give one out transaction with the new column and moved flag.
//   out channel (out_valid/out_ready/out_data): registered result.
// Sequencing:
//   default and clear-all finish in the idle state (word valid bits
//   cleared, fill pattern chosen). set and clear are a read-modify-write
//   of one bitmap word (ram read state, then write state). a tab scans
//   32-bit words through one shared scan unit, each word in a ram read
//   state and then an evaluate state, from the cursor word to the line
//   limit word or to word 0. tabs with nothing to scan go straight to the
//   done state. in_ready is high only while the sequencer is idle.
// Reset:
//   all word valid bits clear with the fill pattern at a stop every eighth
//   column, so the map reads as the default at once; no clearing pass.
// Stall:
//   a finished tab result waits in the sequencer until the output register
//   is free; no new command is taken while a result is held.

module tab_stop_table
	import tst_pkg::*;
#(
	parameter int NUM_COLUMNS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int DEPTH = (NUM_COLUMNS + WORD_W - 1) / WORD_W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [7:0] MAX_COL = (NUM_COLUMNS - 1 > 255) ? 8'd255 : 8'(NUM_COLUMNS - 1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_RMW_RD  = 3'd1;
	localparam logic [2:0] ST_RMW_WR  = 3'd2;
	localparam logic [2:0] ST_SCAN_RD = 3'd3;
	localparam logic [2:0] ST_SCAN_EV = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;

	logic [2:0]       state_q;
	logic [DEPTH-1:0] valid_q;
	logic             fill_q;
	logic             set_q;
	logic             back_q;
	logic             first_q;
	logic [CWI_W-1:0] w_q;
	logic [CWI_W-1:0] last_w_q;
	logic [7:0]       start_q;
	logic [7:0]       lim_q;
	logic [IDX_W-1:0] bit_q;
	out_item_t        res_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [7:0]        col_sat;
	logic [7:0]        lim_sat;
	logic [7:0]        fwd_start;
	logic [7:0]        back_start;
	logic              accept;
	logic [AW-1:0]     w_addr;
	logic [WORD_W-1:0] fill_word;
	logic [WORD_W-1:0] ram_rdata;
	logic [WORD_W-1:0] eff_word;
	logic [WORD_W-1:0] wr_word;
	logic              ram_we;
	logic              ram_re;
	find_req_t         freq;
	find_rsp_t         frsp;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// saturate columns to the table
	assign col_sat    = (in_data.column > MAX_COL) ? MAX_COL : in_data.column;
	assign lim_sat    = (in_data.line_max_col > MAX_COL) ? MAX_COL : in_data.line_max_col;
	assign fwd_start  = col_sat + 8'd1;
	assign back_start = col_sat - 8'd1;

	// invalid words read as the fill pattern
	assign w_addr    = AW'(w_q);
	assign fill_word = fill_q ? DEFAULT_WORD : '0;
	assign eff_word  = valid_q[w_addr] ? ram_rdata : fill_word;

	// read-modify-write data for set and clear
	always_comb begin
		wr_word        = eff_word;
		wr_word[bit_q] = set_q;
	end

	assign ram_we = (state_q == ST_RMW_WR);
	assign ram_re = (state_q == ST_RMW_RD) || (state_q == ST_SCAN_RD);

	// scan window for the current word
	always_comb begin
		freq.word     = eff_word;
		freq.backward = back_q;
		if (back_q) begin
			freq.lo = '0;
			freq.hi = first_q ? start_q[IDX_W-1:0] : IDX_W'(WORD_W - 1);
		end else begin
			freq.lo = first_q ? start_q[IDX_W-1:0] : '0;
			freq.hi = (w_q == last_w_q) ? lim_q[IDX_W-1:0] : IDX_W'(WORD_W - 1);
		end
	end

	tst_find u_find (
		.req(freq),
		.rsp(frsp)
	);

	tst_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(w_addr),
		.wdata(wr_word),
		.re   (ram_re),
		.raddr(w_addr),
		.rdata(ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			fill_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lim_q <= lim_sat;
						bit_q <= col_sat[IDX_W-1:0];
						unique case (in_data.cmd)
							CMD_SET, CMD_CLEAR: begin
								set_q   <= (in_data.cmd == CMD_SET);
								w_q     <= col_sat[7:IDX_W];
								state_q <= ST_RMW_RD;
							end
							CMD_DEFAULT, CMD_CLEAR_ALL: begin
								valid_q <= '0;
								fill_q  <= (in_data.cmd == CMD_DEFAULT);
							end
							CMD_FORWARD: begin
								back_q  <= 1'b0;
								first_q <= 1'b1;
								if (col_sat >= lim_sat) begin
									res_q   <= '{new_column: lim_sat, moved: 1'b0};
									state_q <= ST_DONE;
								end else begin
									start_q  <= fwd_start;
									w_q      <= fwd_start[7:IDX_W];
									last_w_q <= lim_sat[7:IDX_W];
									state_q  <= ST_SCAN_RD;
								end
							end
							CMD_BACK: begin
								back_q  <= 1'b1;
								first_q <= 1'b1;
								if (col_sat == 8'd0) begin
									res_q   <= '{new_column: 8'd0, moved: 1'b0};
									state_q <= ST_DONE;
								end else begin
									start_q <= back_start;
									w_q     <= back_start[7:IDX_W];
									state_q <= ST_SCAN_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RMW_RD: begin
					state_q <= ST_RMW_WR;
				end
				ST_RMW_WR: begin
					valid_q[w_addr] <= 1'b1;
					state_q         <= ST_IDLE;
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_EV;
				end
				ST_SCAN_EV: begin
					first_q <= 1'b0;
					priority if (frsp.found) begin
						res_q   <= '{new_column: {w_q, frsp.idx}, moved: 1'b1};
						state_q <= ST_DONE;
					end else if (!back_q && (w_q == last_w_q)) begin
						res_q   <= '{new_column: lim_q, moved: 1'b1};
						state_q <= ST_DONE;
					end else if (back_q && (w_q == '0)) begin
						res_q   <= '{new_column: 8'd0, moved: 1'b1};
						state_q <= ST_DONE;
					end else begin
						w_q     <= back_q ? w_q - CWI_W'(1) : w_q + CWI_W'(1);
						state_q <= ST_SCAN_RD;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a tab command always leaves idle
	a_tab_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_data.cmd == CMD_FORWARD || in_data.cmd == CMD_BACK)
		|=> state_q != ST_IDLE)
		else $error("tab command did not start the sequencer");

	// forward scan never runs past the line limit word
	a_fwd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_EV) && !back_q |-> w_q <= last_w_q)
		else $error("forward scan passed the limit word");

	// ram write only after its read
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(state_q) == ST_RMW_RD)
		else $error("bitmap write without preceding read");

	// clear-all leaves an empty map
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_data.cmd == CMD_CLEAR_ALL) |=> (valid_q == '0) && !fill_q)
		else $error("clear-all did not empty the map");

	// a new result is loaded only into a free output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_valid_q && !out_ready |=> state_q == ST_DONE)
		else $error("result dropped while output stalled");

endmodule

[rtl/tst_ram.sv]
// generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module tst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/tst_find.sv]
// shared word scan unit: lowest or highest set bit within a bit window
// depends on tst_pkg
`timescale 1ns / 1ps

module tst_find
	import tst_pkg::*;
(
	input  find_req_t req,
	output find_rsp_t rsp
);

	logic [WORD_W-1:0] masked;

	// keep only bits inside [lo, hi]
	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			masked[i] = req.word[i] && (IDX_W'(i) >= req.lo) && (IDX_W'(i) <= req.hi);
		end
	end

	// priority pick: last assignment wins
	always_comb begin
		rsp.found = |masked;
		rsp.idx   = '0;
		if (req.backward) begin
			for (int i = 0; i < WORD_W; i++) begin
				if (masked[i]) rsp.idx = IDX_W'(i);
			end
		end else begin
			for (int i = WORD_W - 1; i >= 0; i--) begin
				if (masked[i]) rsp.idx = IDX_W'(i);
			end
		end
	end

endmodule
